### rtl/bfp_pkg.sv
// Shared types and constants of the boot frame parser.
package bfp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_HEAD_FIRST   = 3'd0;
    localparam logic [2:0] CFG_HEAD_SECOND  = 3'd1;
    localparam logic [2:0] CFG_CONNECT_CODE = 3'd2;
    localparam logic [2:0] CFG_DATA_CODE    = 3'd3;
    localparam logic [2:0] CFG_FINISH_CODE  = 3'd4;
    localparam logic [2:0] CFG_ACK_VALUE    = 3'd5;
    localparam logic [2:0] CFG_NACK_VALUE   = 3'd6;
    localparam logic [2:0] CFG_APP_BASE     = 3'd7;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_HEAD_FIRST   = 8'h55;
    localparam logic [7:0]  RST_HEAD_SECOND  = 8'hAA;
    localparam logic [7:0]  RST_CONNECT_CODE = 8'h01;
    localparam logic [7:0]  RST_DATA_CODE    = 8'h02;
    localparam logic [7:0]  RST_FINISH_CODE  = 8'h03;
    localparam logic [7:0]  RST_ACK_VALUE    = 8'h79;
    localparam logic [7:0]  RST_NACK_VALUE   = 8'h1F;
    localparam logic [31:0] RST_APP_BASE     = 32'h0800_4000;

    // Result kinds
    localparam logic [1:0] KIND_RESP  = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_JUMP  = 2'd3;

    typedef enum logic [3:0] {
        ST_HEAD1,
        ST_HEAD2,
        ST_CMD,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CHECK,
        ST_NACK,
        ST_ERASE,
        ST_ACK,
        ST_RD,
        ST_WRITE,
        ST_FIN_ACK,
        ST_JUMP
    } t_state;

    typedef enum logic [2:0] {
        EMIT_NACK,
        EMIT_ACK,
        EMIT_ERASE,
        EMIT_WRITE,
        EMIT_JUMP
    } t_emit;

    typedef struct packed {
        logic  cap_cmd;
        logic  cap_len_lo;
        logic  cap_len_hi;
        logic  cap_payload;
        logic  rd_clr;
        logic  rd_en;
        logic  rd_inc;
        logic  set_addr;
        logic  adv_addr;
        logic  load;
        t_emit emit;
        logic  last;
    } t_dp_cmd;

    typedef struct packed {
        logic head_first_hit;
        logic head_second_hit;
        logic len_too_big;
        logic len_zero;
        logic len_empty;
        logic count_done;
        logic sum_ok;
        logic is_connect;
        logic is_data;
        logic is_finish;
        logic rd_done;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/bfp_dp.sv
// Datapath of the boot frame parser: config, frame fields, payload buffer, result register.
module bfp_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic [7:0]        i_rx_byte,
    input  bfp_pkg::t_dp_cmd  i_cmd,
    output bfp_pkg::t_dp_sts  o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_out_byte,
    output logic [31:0]       o_flash_address,
    output logic              o_last
);
    import bfp_pkg::*;

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  r_head_first, r_head_second, r_connect_code, r_data_code;
    logic [7:0]  r_finish_code, r_ack_value, r_nack_value;
    logic [31:0] r_app_base;

    logic [7:0]    r_command;
    logic [7:0]    r_len_lo;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_byte_count;
    logic [7:0]    r_sum;
    logic [31:0]   r_wr_addr;
    logic [CW-1:0] r_rd_idx;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [MAX_PAYLOAD];

    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [7:0]    r_out_byte;
    logic [31:0]   r_flash_address;
    logic          r_last;

    logic [15:0]   len_full;
    logic [CW:0]   count_inc;
    logic [CW:0]   rd_inc;

    assign len_full  = {i_rx_byte, r_len_lo};
    assign count_inc = {1'b0, r_byte_count} + 1'b1;
    assign rd_inc    = {1'b0, r_rd_idx} + 1'b1;

    always_comb begin
        o_sts.head_first_hit  = (i_rx_byte == r_head_first);
        o_sts.head_second_hit = (i_rx_byte == r_head_second);
        o_sts.len_too_big     = (len_full > 16'(MAX_PAYLOAD));
        o_sts.len_zero        = (len_full == 16'd0);
        o_sts.len_empty       = (r_len == '0);
        o_sts.count_done      = (count_inc >= {1'b0, r_len});
        o_sts.sum_ok          = (i_rx_byte == r_sum);
        o_sts.is_connect      = (r_command == r_connect_code);
        o_sts.is_data         = (r_command == r_data_code);
        o_sts.is_finish       = (r_command == r_finish_code);
        o_sts.rd_done         = (rd_inc == {1'b0, r_len});
        o_sts.out_free        = !r_out_valid || i_out_ready;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first   <= RST_HEAD_FIRST;
            r_head_second  <= RST_HEAD_SECOND;
            r_connect_code <= RST_CONNECT_CODE;
            r_data_code    <= RST_DATA_CODE;
            r_finish_code  <= RST_FINISH_CODE;
            r_ack_value    <= RST_ACK_VALUE;
            r_nack_value   <= RST_NACK_VALUE;
            r_app_base     <= RST_APP_BASE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEAD_FIRST:   r_head_first   <= i_cfg_data[7:0];
                CFG_HEAD_SECOND:  r_head_second  <= i_cfg_data[7:0];
                CFG_CONNECT_CODE: r_connect_code <= i_cfg_data[7:0];
                CFG_DATA_CODE:    r_data_code    <= i_cfg_data[7:0];
                CFG_FINISH_CODE:  r_finish_code  <= i_cfg_data[7:0];
                CFG_ACK_VALUE:    r_ack_value    <= i_cfg_data[7:0];
                CFG_NACK_VALUE:   r_nack_value   <= i_cfg_data[7:0];
                CFG_APP_BASE:     r_app_base     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame fields and write address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command    <= '0;
            r_len_lo     <= '0;
            r_len        <= '0;
            r_byte_count <= '0;
            r_sum        <= '0;
            r_rd_idx     <= '0;
            r_wr_addr    <= RST_APP_BASE;
        end else begin
            if (i_cmd.cap_cmd) begin
                r_command <= i_rx_byte;
                r_sum     <= i_rx_byte;
            end
            if (i_cmd.cap_len_lo) begin
                r_len_lo <= i_rx_byte;
                r_sum    <= r_sum + i_rx_byte;
            end
            if (i_cmd.cap_len_hi) begin
                // only used when it fits, so the low bits are the whole length
                r_len        <= len_full[CW-1:0];
                r_sum        <= r_sum + i_rx_byte;
                r_byte_count <= '0;
            end
            if (i_cmd.cap_payload) begin
                r_sum        <= r_sum + i_rx_byte;
                r_byte_count <= count_inc[CW-1:0];
            end
            if (i_cmd.rd_clr) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_inc) begin
                r_rd_idx <= rd_inc[CW-1:0];
            end
            if (i_cmd.set_addr) begin
                r_wr_addr <= r_app_base;
            end else if (i_cmd.adv_addr) begin
                r_wr_addr <= r_wr_addr + 32'(r_len);
            end
        end
    end

    // Payload buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_payload) begin
            r_mem[r_byte_count[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            case (i_cmd.emit)
                EMIT_NACK: begin
                    r_kind          <= KIND_RESP;
                    r_out_byte      <= r_nack_value;
                    r_flash_address <= '0;
                end
                EMIT_ACK: begin
                    r_kind          <= KIND_RESP;
                    r_out_byte      <= r_ack_value;
                    r_flash_address <= '0;
                end
                EMIT_ERASE: begin
                    r_kind          <= KIND_ERASE;
                    r_out_byte      <= '0;
                    r_flash_address <= r_app_base;
                end
                EMIT_WRITE: begin
                    r_kind          <= KIND_WRITE;
                    r_out_byte      <= r_rd_data;
                    r_flash_address <= r_wr_addr + 32'(r_rd_idx);
                end
                EMIT_JUMP: begin
                    r_kind          <= KIND_JUMP;
                    r_out_byte      <= '0;
                    r_flash_address <= r_app_base;
                end
                default: begin
                    r_kind          <= KIND_RESP;
                    r_out_byte      <= r_nack_value;
                    r_flash_address <= '0;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_out_byte;
    assign o_flash_address = r_flash_address;
    assign o_last          = r_last;

endmodule

### rtl/bfp_ctrl.sv
// Controller of the boot frame parser: frame phase and result sequencing.
module bfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bfp_pkg::t_dp_sts  i_sts,
    output bfp_pkg::t_dp_cmd  o_cmd
);
    import bfp_pkg::*;

    t_state r_state, n_state;
    logic   rx_phase;
    logic   take;

    always_comb begin
        case (r_state)
            ST_HEAD1, ST_HEAD2, ST_CMD, ST_LEN_LO, ST_LEN_HI,
            ST_PAYLOAD, ST_CHECK: rx_phase = 1'b1;
            default:              rx_phase = 1'b0;
        endcase
    end

    assign o_in_ready = rx_phase;
    assign take       = rx_phase && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEAD1;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HEAD1: begin
                if (take && i_sts.head_first_hit) n_state = ST_HEAD2;
            end
            ST_HEAD2: begin
                if (take) begin
                    if (i_sts.head_second_hit)     n_state = ST_CMD;
                    else if (i_sts.head_first_hit) n_state = ST_HEAD2;
                    else                           n_state = ST_HEAD1;
                end
            end
            ST_CMD: begin
                if (take) n_state = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                if (take) n_state = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                if (take) begin
                    if (i_sts.len_too_big)   n_state = ST_NACK;
                    else if (i_sts.len_zero) n_state = ST_CHECK;
                    else                     n_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (take && i_sts.count_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (take) begin
                    if (!i_sts.sum_ok)          n_state = ST_NACK;
                    else if (i_sts.is_connect)  n_state = ST_ERASE;
                    // an empty data frame has no writes, only the ack
                    else if (i_sts.is_data)     n_state = i_sts.len_empty ? ST_ACK : ST_RD;
                    else if (i_sts.is_finish)   n_state = ST_FIN_ACK;
                    else                        n_state = ST_NACK;
                end
            end
            ST_NACK: begin
                if (i_sts.out_free) n_state = ST_HEAD1;
            end
            ST_ERASE: begin
                if (i_sts.out_free) n_state = ST_ACK;
            end
            ST_ACK: begin
                if (i_sts.out_free) n_state = ST_HEAD1;
            end
            ST_RD: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_sts.out_free) n_state = i_sts.rd_done ? ST_ACK : ST_RD;
            end
            ST_FIN_ACK: begin
                if (i_sts.out_free) n_state = ST_JUMP;
            end
            ST_JUMP: begin
                if (i_sts.out_free) n_state = ST_HEAD1;
            end
            default: n_state = ST_HEAD1;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.emit = EMIT_NACK;
        case (r_state)
            ST_CMD:     o_cmd.cap_cmd     = take;
            ST_LEN_LO:  o_cmd.cap_len_lo  = take;
            ST_LEN_HI:  o_cmd.cap_len_hi  = take;
            ST_PAYLOAD: o_cmd.cap_payload = take;
            ST_CHECK:   o_cmd.rd_clr      = take;
            ST_NACK: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.emit = EMIT_NACK;
                o_cmd.last = 1'b1;
            end
            ST_ERASE: begin
                o_cmd.load     = i_sts.out_free;
                o_cmd.set_addr = i_sts.out_free;
                o_cmd.emit     = EMIT_ERASE;
            end
            ST_ACK: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.emit = EMIT_ACK;
                o_cmd.last = 1'b1;
            end
            ST_RD: o_cmd.rd_en = 1'b1;
            ST_WRITE: begin
                o_cmd.load     = i_sts.out_free;
                o_cmd.emit     = EMIT_WRITE;
                o_cmd.rd_inc   = i_sts.out_free;
                o_cmd.adv_addr = i_sts.out_free && i_sts.rd_done;
            end
            ST_FIN_ACK: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.emit = EMIT_ACK;
            end
            ST_JUMP: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.emit = EMIT_JUMP;
                o_cmd.last = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### rtl/boot_frame_parser.sv
// Top level of the boot frame parser: controller plus datapath.
//
// Boot loader frame parser. Received bytes come in one item per accepted
// handshake; a frame is header (two bytes), command, little-endian 16-bit
// length, payload and an 8-bit additive checksum over command, length and
// payload. Header, command codes, ack/nack values and the application base
// address are set through the config port; the user must write them only
// while the parser is idle, the block itself does not enforce it. Results
// leave one per item on the output channel; o_last marks the final result of
// the byte that caused them. Input flow: every byte that only advances the
// parse is taken as soon as it is valid, and the parser is ready again the
// next cycle even while a result still waits in the output register. A byte
// that ends a frame blocks input until its results are loaded into the output
// register: nack, erase, ack and jump each wait for a free output register,
// and each payload byte of a data frame passes a read state and then a write
// state, since each write re-reads the payload buffer through its registered
// read port. An empty data frame blocks input only for its ack.
// Lengths above MAX_PAYLOAD are rejected at the length high byte with a nack.
module boot_frame_parser #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // received byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_flash_address,
    output logic        o_last
);
    import bfp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config registers are plain flops; a write always lands
    assign o_cfg_ready = 1'b1;

    bfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_flash_address (o_flash_address),
        .o_last          (o_last)
    );

endmodule
